### rtl/core/tts_pkg.sv
`timescale 1ns / 1ps

package tts_pkg;

    // screen geometry
    localparam int SCREEN_WIDTH  = 80;
    localparam int SCREEN_HEIGHT = 25;
    localparam int CELL_COUNT    = SCREEN_WIDTH * SCREEN_HEIGHT;

    // internal widths follow the geometry
    localparam int COL_W  = $clog2(SCREEN_WIDTH);
    localparam int ROW_W  = $clog2(SCREEN_HEIGHT);
    localparam int ADDR_W = $clog2(CELL_COUNT);

    // character and attribute codes
    localparam logic [7:0] CHAR_NEWLINE = 8'd10;
    localparam logic [7:0] CHAR_SPACE   = 8'd32;
    localparam logic [7:0] COLOUR_RESET = 8'd31;

    // request codes
    typedef enum logic [1:0] {
        REQ_PUT    = 2'd0,
        REQ_PUT_XY = 2'd1,
        REQ_CLEAR  = 2'd2,
        REQ_READ   = 2'd3
    } t_req_type;

    // request payload
    typedef struct packed {
        t_req_type   req_type;
        logic [7:0]  char_code;
        logic [7:0]  cell_colour;
        logic [6:0]  column_x;
        logic [4:0]  row_y;
    } t_in_req;

    // result payload
    typedef struct packed {
        logic [15:0] read_cell;
        logic [6:0]  cursor_column;
        logic [4:0]  cursor_row;
        logic        scrolled;
    } t_out_rsp;

    // controller states
    typedef enum logic [2:0] {
        ST_INIT,
        ST_IDLE,
        ST_EXEC,
        ST_CLEAR,
        ST_SCROLL,
        ST_DONE
    } t_state;

    // controller to datapath commands
    typedef struct packed {
        logic latch;
        logic exec;
        logic cnt_clr;
        logic fill;
        logic fill_init;
        logic blank_row;
        logic out_load;
    } t_dp_cmd;

    // datapath to controller status
    typedef struct packed {
        logic req_clear;
        logic need_scroll;
        logic cnt_all_last;
        logic cnt_row_last;
    } t_dp_sts;

endpackage

### rtl/core/tts_ctrl.sv
`timescale 1ns / 1ps

module tts_ctrl import tts_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    output logic    o_in_stall,
    output logic    o_out_valid,
    input  logic    i_out_stall,
    input  t_dp_sts i_sts,
    output t_dp_cmd o_cmd
);

    t_state r_state;
    t_state n_state;
    logic   r_out_valid;
    logic   n_out_valid;
    logic   out_free;

    // result register can take a new request result
    assign out_free = !r_out_valid || !i_out_stall;

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_INIT: begin
                if (i_sts.cnt_all_last) n_state = ST_IDLE;
            end
            ST_IDLE: begin
                if (i_in_valid) n_state = ST_EXEC;
            end
            ST_EXEC: begin
                if (i_sts.req_clear) n_state = ST_CLEAR;
                else if (i_sts.need_scroll) n_state = ST_SCROLL;
                else n_state = ST_DONE;
            end
            ST_CLEAR: begin
                if (i_sts.cnt_all_last) n_state = ST_DONE;
            end
            ST_SCROLL: begin
                if (i_sts.cnt_row_last) n_state = ST_DONE;
            end
            ST_DONE: begin
                if (out_free) n_state = ST_IDLE;
            end
            default: n_state = ST_INIT;
        endcase
    end

    // command outputs
    always_comb begin
        o_cmd = '0;
        case (r_state)
            ST_INIT: begin
                o_cmd.fill      = 1'b1;
                o_cmd.fill_init = 1'b1;
            end
            ST_IDLE: begin
                o_cmd.latch = i_in_valid;
            end
            ST_EXEC: begin
                o_cmd.exec    = 1'b1;
                o_cmd.cnt_clr = 1'b1;
            end
            ST_CLEAR: begin
                o_cmd.fill = 1'b1;
            end
            ST_SCROLL: begin
                o_cmd.blank_row = 1'b1;
            end
            ST_DONE: begin
                o_cmd.out_load = out_free;
            end
            default: o_cmd = '0;
        endcase
    end

    // result valid flag
    always_comb begin
        n_out_valid = r_out_valid && i_out_stall;
        if (o_cmd.out_load) n_out_valid = 1'b1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_INIT;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_in_stall  = (r_state != ST_IDLE);
    assign o_out_valid = r_out_valid;

    // an accepted request always goes to execution next
    a_accept_exec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> (r_state == ST_EXEC))
        else $error("accepted request did not start execution");

    // a new result only appears out of the done state
    a_rise_from_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> ($past(r_state) == ST_DONE))
        else $error("result valid rose outside done state");

    // blanking a row ends after the last column
    a_scroll_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_SCROLL && i_sts.cnt_row_last) |=> (r_state == ST_DONE))
        else $error("row blanking did not finish");

    // reset always starts the clearing pass
    a_reset_init: assert property (@(posedge i_clk)
        !i_rst_n |=> (r_state == ST_INIT && !r_out_valid))
        else $error("reset did not start clearing pass");

endmodule

### rtl/core/tts_dp.sv
`timescale 1ns / 1ps

module tts_dp import tts_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_dp_cmd    i_cmd,
    output t_dp_sts    o_sts,
    input  t_in_req    i_in_req,
    input  logic       i_cfg_we,
    input  logic [7:0] i_cfg_wdata,
    output t_out_rsp   o_out_rsp
);

    // screen store, rows held in rotation from r_base
    logic [15:0]       r_mem [CELL_COUNT];
    logic [15:0]       r_rd_data;

    t_in_req           r_req;
    logic [7:0]        r_colour;
    logic [COL_W-1:0]  r_col;
    logic [COL_W-1:0]  n_col;
    logic [ROW_W-1:0]  r_row;
    logic [ROW_W-1:0]  n_row;
    logic [ROW_W-1:0]  r_base;
    logic [ROW_W-1:0]  n_base;
    logic [ROW_W-1:0]  r_blank_row;
    logic [ADDR_W-1:0] r_cnt;
    logic              r_scrolled;
    t_out_rsp          r_out;

    logic              is_nl;
    logic              on_screen;
    logic              col_last;
    logic              row_last;
    logic              need_scroll;
    logic              we;
    logic [ADDR_W-1:0] waddr;
    logic [15:0]       wdata;
    logic [ADDR_W-1:0] raddr;
    logic [ADDR_W-1:0] cursor_addr;
    logic [ADDR_W-1:0] xy_addr;

    // logical row and column to store address
    function automatic logic [ADDR_W-1:0] cell_addr(
        input logic [ROW_W-1:0] row,
        input logic [COL_W-1:0] col,
        input logic [ROW_W-1:0] base
    );
        logic [ROW_W:0] sum;
        sum = {1'b0, row} + {1'b0, base};
        if (sum >= (ROW_W+1)'(SCREEN_HEIGHT)) sum = sum - (ROW_W+1)'(SCREEN_HEIGHT);
        return ADDR_W'(sum[ROW_W-1:0]) * ADDR_W'(SCREEN_WIDTH) + ADDR_W'(col);
    endfunction

    // request decode
    assign is_nl     = (r_req.char_code == CHAR_NEWLINE);
    assign on_screen = (int'(r_req.column_x) < SCREEN_WIDTH) &&
                       (int'(r_req.row_y) < SCREEN_HEIGHT);
    assign col_last  = (r_col == COL_W'(SCREEN_WIDTH - 1));
    assign row_last  = (r_row == ROW_W'(SCREEN_HEIGHT - 1));
    assign need_scroll = (r_req.req_type == REQ_PUT) && row_last && (is_nl || col_last);

    assign cursor_addr = cell_addr(r_row, r_col, r_base);
    assign xy_addr     = cell_addr(ROW_W'(r_req.row_y), COL_W'(r_req.column_x), r_base);
    assign raddr       = xy_addr;

    // cursor and row rotation update
    always_comb begin
        n_col  = r_col;
        n_row  = r_row;
        n_base = r_base;
        if (i_cmd.exec && r_req.req_type == REQ_PUT) begin
            if (is_nl || col_last) begin
                n_col = '0;
                if (row_last) begin
                    if (r_base == ROW_W'(SCREEN_HEIGHT - 1)) n_base = '0;
                    else n_base = r_base + ROW_W'(1);
                end else begin
                    n_row = r_row + ROW_W'(1);
                end
            end else begin
                n_col = r_col + COL_W'(1);
            end
        end
    end

    // store write port select
    always_comb begin
        we    = 1'b0;
        waddr = cursor_addr;
        wdata = {r_colour, r_req.char_code};
        if (i_cmd.fill) begin
            we    = 1'b1;
            waddr = r_cnt;
            wdata = {(i_cmd.fill_init ? COLOUR_RESET : r_colour), CHAR_SPACE};
        end else if (i_cmd.blank_row) begin
            we    = 1'b1;
            waddr = ADDR_W'(r_blank_row) * ADDR_W'(SCREEN_WIDTH) + r_cnt;
            wdata = {r_colour, CHAR_SPACE};
        end else if (i_cmd.exec) begin
            if (r_req.req_type == REQ_PUT && !is_nl) begin
                we    = 1'b1;
                waddr = cursor_addr;
                wdata = {r_colour, r_req.char_code};
            end else if (r_req.req_type == REQ_PUT_XY && on_screen) begin
                we    = 1'b1;
                waddr = xy_addr;
                wdata = {r_req.cell_colour, r_req.char_code};
            end
        end
    end

    // screen store
    always_ff @(posedge i_clk) begin
        if (we) r_mem[waddr] <= wdata;
        if (i_cmd.exec) r_rd_data <= r_mem[raddr];
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_colour   <= COLOUR_RESET;
            r_col      <= '0;
            r_row      <= '0;
            r_base     <= '0;
            r_cnt      <= '0;
            r_scrolled <= 1'b0;
        end else begin
            if (i_cfg_we) r_colour <= i_cfg_wdata;
            r_col  <= n_col;
            r_row  <= n_row;
            r_base <= n_base;
            if (i_cmd.cnt_clr) r_cnt <= '0;
            else if (i_cmd.fill || i_cmd.blank_row) r_cnt <= r_cnt + ADDR_W'(1);
            if (i_cmd.exec) r_scrolled <= need_scroll;
        end
    end

    // request and scroll payload registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.latch) r_req <= i_in_req;
        if (i_cmd.exec) r_blank_row <= r_base;
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_out.read_cell     <= (r_req.req_type == REQ_READ && on_screen) ? r_rd_data : '0;
            r_out.cursor_column <= 7'(r_col);
            r_out.cursor_row    <= 5'(r_row);
            r_out.scrolled      <= r_scrolled;
        end
    end

    assign o_out_rsp = r_out;

    // status to controller
    assign o_sts.req_clear    = (r_req.req_type == REQ_CLEAR);
    assign o_sts.need_scroll  = need_scroll;
    assign o_sts.cnt_all_last = (r_cnt == ADDR_W'(CELL_COUNT - 1));
    assign o_sts.cnt_row_last = (r_cnt == ADDR_W'(SCREEN_WIDTH - 1));

    // cursor and rotation stay on screen
    a_cursor_on_screen: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (int'(r_row) < SCREEN_HEIGHT) && (int'(r_col) < SCREEN_WIDTH)
        && (int'(r_base) < SCREEN_HEIGHT))
        else $error("cursor or row base off screen");

    // a scroll leaves the cursor on the bottom row at column zero
    a_scroll_cursor: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.exec && need_scroll) |=> (row_last && r_col == '0 && r_scrolled))
        else $error("scroll left cursor misplaced");

    // the row base only moves on a scroll
    a_base_moves: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_cmd.exec && need_scroll) |=> $stable(r_base))
        else $error("row base moved without scroll");

endmodule

### rtl/core/text_terminal_scroll.sv
`timescale 1ns / 1ps
// channel  | direction | handshake              | payload
// ---------+-----------+------------------------+----------------------
// request  | in        | i_in_valid / o_in_stall | i_in_req  (t_in_req)
// result   | out       | o_out_valid / i_out_stall | o_out_rsp (t_out_rsp)
// config   | in        | i_cfg_we (no wait)     | i_cfg_wdata (colour)
//
// put, put at coordinates, newline and read go from accept through the execute
// and done states to the result; a put or newline that scrolls also blanks
// one row, and rows rotate through a base pointer, so no cells are copied
// clear writes every cell in the clear state, one cell per store write
// after reset a pass clearing all SCREEN_WIDTH * SCREEN_HEIGHT (2000) cells runs
// with the request side stalled; a request is accepted while a result waits

module text_terminal_scroll import tts_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_stall,
    input  t_in_req    i_in_req,
    output logic       o_out_valid,
    input  logic       i_out_stall,
    output t_out_rsp   o_out_rsp,
    input  logic       i_cfg_we,
    input  logic [7:0] i_cfg_wdata
);

    t_dp_cmd cmd;
    t_dp_sts sts;

    // sequencer
    tts_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .i_sts       (sts),
        .o_cmd       (cmd)
    );

    // screen store, cursor and result register
    tts_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .i_in_req    (i_in_req),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .o_out_rsp   (o_out_rsp)
    );

endmodule

### bench/tb_text_terminal_scroll.sv
`timescale 1ns / 1ps

module tb_text_terminal_scroll;
    import tts_pkg::*;

    localparam int CYCLE_LIMIT = 1_000_000;
    localparam int HOLD_CYCLES = 400;
    localparam int SETTLE_CYCLES = 120;

    // clock, reset and block inputs, all known from time zero
    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       in_valid = 1'b0;
    t_in_req    in_req = '0;
    logic       out_stall = 1'b0;
    logic       cfg_we = 1'b0;
    logic [7:0] cfg_wdata = 8'd0;

    logic     in_stall;
    logic     out_valid;
    t_out_rsp out_rsp;

    // shadow of the terminal state
    logic [15:0] screen_shadow [CELL_COUNT];
    int unsigned cursor_col_shadow;
    int unsigned cursor_row_shadow;
    logic [7:0]  colour_shadow;

    // cursor and cell values still owed by the block
    t_out_rsp    pending_rsp [$];

    bit          idle_on = 1'b0;
    bit          hold_ask = 1'b0;
    int          hold_left = 0;
    int          error_count = 0;
    int          cycle_count = 0;
    int          requests_sent = 0;
    int          results_checked = 0;
    int          scrolls_seen = 0;
    int          clears_sent = 0;
    int          reads_sent = 0;
    int          colours_used = 0;

    text_terminal_scroll u_top (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_req    (in_req),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_rsp   (out_rsp),
        .i_cfg_we    (cfg_we),
        .i_cfg_wdata (cfg_wdata)
    );

    always #1 clk = ~clk;

    // watchdog
    always @(posedge clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycle_count, pending_rsp.size());
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // blank one row of the shadow in the current text colour
    function automatic void blank_shadow_row(int unsigned row);
        for (int unsigned x = 0; x < SCREEN_WIDTH; x++)
            screen_shadow[row * SCREEN_WIDTH + x] = {colour_shadow, CHAR_SPACE};
    endfunction

    // cursor down one row, scrolling from the last row; returns the scroll flag
    function automatic logic cursor_down();
        if (cursor_row_shadow + 1 >= SCREEN_HEIGHT) begin
            for (int unsigned i = 0; i < CELL_COUNT - SCREEN_WIDTH; i++)
                screen_shadow[i] = screen_shadow[i + SCREEN_WIDTH];
            blank_shadow_row(SCREEN_HEIGHT - 1);
            return 1'b1;
        end
        cursor_row_shadow++;
        return 1'b0;
    endfunction

    // apply one request to the shadow and return the result it should give
    function automatic t_out_rsp predict_terminal(t_in_req req);
        t_out_rsp rsp;
        bit       on_screen;
        rsp = '0;
        on_screen = (req.column_x < SCREEN_WIDTH) && (req.row_y < SCREEN_HEIGHT);
        case (req.req_type)
            REQ_PUT: begin
                if (req.char_code == CHAR_NEWLINE) begin
                    cursor_col_shadow = 0;
                    rsp.scrolled = cursor_down();
                end else begin
                    screen_shadow[cursor_row_shadow * SCREEN_WIDTH + cursor_col_shadow] =
                        {colour_shadow, req.char_code};
                    cursor_col_shadow++;
                    if (cursor_col_shadow >= SCREEN_WIDTH) begin
                        cursor_col_shadow = 0;
                        rsp.scrolled = cursor_down();
                    end
                end
            end
            REQ_PUT_XY: begin
                if (on_screen)
                    screen_shadow[req.row_y * SCREEN_WIDTH + req.column_x] =
                        {req.cell_colour, req.char_code};
            end
            REQ_CLEAR: begin
                for (int unsigned r = 0; r < SCREEN_HEIGHT; r++)
                    blank_shadow_row(r);
            end
            default: begin
                if (on_screen)
                    rsp.read_cell = screen_shadow[req.row_y * SCREEN_WIDTH + req.column_x];
            end
        endcase
        rsp.cursor_column = 7'(cursor_col_shadow);
        rsp.cursor_row    = 5'(cursor_row_shadow);
        return rsp;
    endfunction

    task automatic report_mismatch(string what, int got, int want);
        error_count++;
        $display("[%0d] mismatch #%0d on result %0d: %s got 0x%0h want 0x%0h",
                 cycle_count, error_count, results_checked, what, got, want);
    endtask

    // result side backpressure, with a long hold on request
    always @(posedge clk) begin
        if (hold_ask) begin
            hold_left = HOLD_CYCLES;
            hold_ask  = 1'b0;
        end
        if (hold_left > 0) begin
            hold_left--;
            out_stall <= 1'b1;
        end else begin
            out_stall <= idle_on && ($urandom_range(99) < 18);
        end
    end

    // compare every accepted result with the oldest expectation
    always @(posedge clk) begin : result_check
        t_out_rsp want;
        if (rst_n && out_valid && !out_stall) begin
            results_checked++;
            if (out_rsp.scrolled)
                scrolls_seen++;
            if (pending_rsp.size() == 0) begin
                report_mismatch("result with none expected", int'(out_rsp), 0);
            end else begin
                want = pending_rsp.pop_front();
                if (out_rsp.read_cell !== want.read_cell)
                    report_mismatch("read_cell", int'(out_rsp.read_cell),
                                    int'(want.read_cell));
                if (out_rsp.cursor_column !== want.cursor_column)
                    report_mismatch("cursor_column", int'(out_rsp.cursor_column),
                                    int'(want.cursor_column));
                if (out_rsp.cursor_row !== want.cursor_row)
                    report_mismatch("cursor_row", int'(out_rsp.cursor_row),
                                    int'(want.cursor_row));
                if (out_rsp.scrolled !== want.scrolled)
                    report_mismatch("scrolled", int'(out_rsp.scrolled),
                                    int'(want.scrolled));
            end
        end
    end

    // offer one request, wait for it to be taken, then predict its result
    task automatic send_request(input t_in_req req);
        while (idle_on && $urandom_range(99) < 18) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_req   <= req;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        if (req.req_type == REQ_CLEAR)
            clears_sent++;
        if (req.req_type == REQ_READ)
            reads_sent++;
        requests_sent++;
        pending_rsp.push_back(predict_terminal(req));
    endtask

    // stop offering and let every owed result come back
    task automatic wait_drained();
        in_valid <= 1'b0;
        while (pending_rsp.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_text_colour(input logic [7:0] colour);
        wait_drained();
        cfg_we    <= 1'b1;
        cfg_wdata <= colour;
        @(posedge clk);
        cfg_we    <= 1'b0;
        colour_shadow = colour;
        colours_used++;
    endtask

    function automatic t_in_req make_req(t_req_type kind, logic [7:0] ch,
                                         logic [7:0] colour, logic [6:0] x, logic [4:0] y);
        t_in_req req;
        req.req_type    = kind;
        req.char_code   = ch;
        req.cell_colour = colour;
        req.column_x    = x;
        req.row_y       = y;
        return req;
    endfunction

    // mostly typed text with newlines, some placed cells, reads and rare clears
    function automatic t_in_req random_req();
        t_in_req     req;
        int unsigned pick;
        req.char_code   = 8'($urandom);
        req.cell_colour = 8'($urandom);
        req.column_x    = 7'($urandom);
        req.row_y       = 5'($urandom);
        pick = $urandom_range(999);
        if (pick < 15) begin
            req.req_type = REQ_CLEAR;
        end else if (pick < 715) begin
            req.req_type = REQ_PUT;
            if ($urandom_range(99) < 12)
                req.char_code = CHAR_NEWLINE;
        end else if (pick < 815) begin
            req.req_type = REQ_PUT_XY;
        end else begin
            req.req_type = REQ_READ;
        end
        if ((req.req_type == REQ_PUT_XY || req.req_type == REQ_READ)
                && $urandom_range(99) < 85) begin
            req.column_x = 7'($urandom_range(SCREEN_WIDTH - 1));
            // reads lean toward the row being typed on
            if (req.req_type == REQ_READ && $urandom_range(99) < 40)
                req.row_y = 5'(cursor_row_shadow);
            else
                req.row_y = 5'($urandom_range(SCREEN_HEIGHT - 1));
        end
        return req;
    endfunction

    // edges of every field, each request kind and off-screen coordinates
    task automatic test_directed();
        idle_on = 1'b0;
        send_request(make_req(REQ_PUT, 8'h48, 8'h00, 7'd0, 5'd0));
        send_request(make_req(REQ_PUT, 8'h00, 8'hFF, 7'd127, 5'd31));
        send_request(make_req(REQ_PUT, 8'hFF, 8'h00, 7'd0, 5'd0));
        send_request(make_req(REQ_PUT, CHAR_NEWLINE, 8'hAA, 7'd85, 5'd21));
        send_request(make_req(REQ_PUT_XY, 8'h00, 8'hFF, 7'd0, 5'd0));
        send_request(make_req(REQ_PUT_XY, 8'hFF, 8'h00, 7'd79, 5'd24));
        send_request(make_req(REQ_PUT_XY, 8'h55, 8'hAA, 7'd80, 5'd0));
        send_request(make_req(REQ_PUT_XY, 8'hAA, 8'h55, 7'd0, 5'd25));
        send_request(make_req(REQ_PUT_XY, 8'hFF, 8'hFF, 7'd127, 5'd31));
        send_request(make_req(REQ_READ, 8'hFF, 8'hFF, 7'd0, 5'd0));
        send_request(make_req(REQ_READ, 8'h00, 8'h00, 7'd1, 5'd0));
        send_request(make_req(REQ_READ, 8'h00, 8'h00, 7'd79, 5'd24));
        send_request(make_req(REQ_READ, 8'h00, 8'h00, 7'd40, 5'd12));
        send_request(make_req(REQ_READ, 8'h00, 8'h00, 7'd80, 5'd0));
        send_request(make_req(REQ_READ, 8'h00, 8'h00, 7'd0, 5'd25));
        send_request(make_req(REQ_READ, 8'h00, 8'h00, 7'd127, 5'd31));
        send_request(make_req(REQ_CLEAR, 8'hFF, 8'hFF, 7'd127, 5'd31));
        send_request(make_req(REQ_READ, 8'h00, 8'h00, 7'd0, 5'd0));
        send_request(make_req(REQ_READ, 8'h00, 8'h00, 7'd79, 5'd24));
        send_request(make_req(REQ_PUT, 8'h5A, 8'h00, 7'd0, 5'd0));
        send_request(make_req(REQ_READ, 8'h00, 8'h00, 7'd0, 5'd1));
    endtask

    task automatic test_random_traffic(input int count, input logic [7:0] colour,
                                       input bit with_idle);
        write_text_colour(colour);
        idle_on = with_idle;
        for (int i = 0; i < count; i++)
            send_request(random_req());
    endtask

    // receiver holds off for a long stretch while requests keep coming
    task automatic test_backpressure();
        write_text_colour(8'($urandom));
        idle_on  = 1'b0;
        hold_ask = 1'b1;
        for (int i = 0; i < 40; i++)
            send_request(random_req());
        idle_on = 1'b1;
    endtask

    initial begin
        cursor_col_shadow = 0;
        cursor_row_shadow = 0;
        colour_shadow     = COLOUR_RESET;
        for (int unsigned r = 0; r < SCREEN_HEIGHT; r++)
            blank_shadow_row(r);

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        test_directed();
        test_random_traffic(400, 8'h00, 1'b0);
        test_random_traffic(400, 8'hFF, 1'b1);
        test_backpressure();
        test_random_traffic(500, 8'($urandom), 1'b1);
        test_random_traffic(450, COLOUR_RESET, 1'b1);

        wait_drained();
        $display("covered %0d requests: %0d reads, %0d clears, %0d scrolls seen",
                 requests_sent, reads_sent, clears_sent, scrolls_seen);
        $display("%0d results checked over %0d colour settings, %0d errors",
                 results_checked, colours_used + 1, error_count);
        if (error_count == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule

### files.f
rtl/core/tts_pkg.sv
rtl/core/tts_ctrl.sv
rtl/core/tts_dp.sv
rtl/core/text_terminal_scroll.sv
bench/tb_text_terminal_scroll.sv
